[src/polyblep_oscillator_assert.svh]
// Assertion macros for the oscillator RTL
`ifndef POLYBLEP_OSCILLATOR_ASSERT_SVH
`define POLYBLEP_OSCILLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PBO_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PBO_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PBO_ASSERT_IMP(label, ante, cons)
`define PBO_ASSERT_NXT(label, ante, cons)
`endif
`endif

[src/pbo_pkg.sv]
// Shared constants, register indices and the tuning gain function for the oscillator
`timescale 1ns / 1ps
package pbo_pkg;
  localparam int unsigned STEP_MAX = 32'd2104533975;
  localparam int          CENT_LIM = 50;
  localparam logic [1:0]  REG_TARGET = 2'd0;
  localparam logic [1:0]  REG_WAVE   = 2'd1;
  localparam logic [1:0]  REG_CENTS  = 2'd2;
  localparam logic [1:0]  REG_COEFF  = 2'd3;

  // Tuning gain in Q2.30 for cents -50..50, series approximation of 2^(c/1200)
  function automatic logic [31:0] tune_gain(input logic signed [6:0] c);
    longint u, u2, u3;
    begin
      u  = longint'(c) * 64'sd620218;
      u2 = (u * u) / 64'sd2147483648;
      u3 = (u2 * u) / 64'sd3221225472;
      tune_gain = 32'(64'sd1073741824 + u + u2 + u3);
    end
  endfunction
endpackage

[src/pbo_serial_mul.sv]
// Shift-and-add multiplier: one multiplier bit per cycle, 64-bit product
`timescale 1ns / 1ps
module pbo_serial_mul import pbo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic        done,
  output logic [63:0] prod
);
  logic [63:0] acc_r, acc_nxt;
  logic [31:0] mcand_r, mcand_nxt;
  logic [31:0] mplier_r, mplier_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  // Add the shifted multiplicand when the low multiplier bit is set
  always_comb begin
    acc_nxt = acc_r; mcand_nxt = mcand_r; mplier_nxt = mplier_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    if (start) begin
      acc_nxt = '0; mcand_nxt = a; mplier_nxt = b; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {1'b0, acc_r[63:1]};
      if (mplier_r[0]) acc_nxt = ({1'b0, acc_r[63:32]} + {1'b0, mcand_r}) << 31
                               | {33'b0, acc_r[31:1]};
      mplier_nxt = {1'b0, mplier_r[31:1]};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt; mcand_r <= mcand_nxt; mplier_r <= mplier_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

[src/pbo_serial_div.sv]
// Restoring divider: one quotient bit per cycle, (t << 30) / dt with t, dt < 2^32
`timescale 1ns / 1ps
module pbo_serial_div import pbo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  logic [32:0] rem_r, rem_nxt;
  logic [61:0] nsh_r, nsh_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  // Shift in one numerator bit, subtract when it fits
  always_comb begin
    rem_nxt = rem_r; nsh_nxt = nsh_r; quo_nxt = quo_r; den_nxt = den_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, nsh_r[61]} - {2'b0, den_r};
    if (start) begin
      rem_nxt = '0; nsh_nxt = {num, 30'b0}; quo_nxt = '0; den_nxt = den;
      cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      nsh_nxt = {nsh_r[60:0], 1'b0};
      if (!trial[33]) begin
        rem_nxt = trial[32:0]; quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], nsh_r[61]}; quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd61) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt; nsh_r <= nsh_nxt; quo_r <= quo_nxt; den_r <= den_nxt; cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

[src/polyblep_oscillator.sv]
// Top level: PolyBLEP oscillator sequencer around a bit-serial multiplier and divider
// Per input transaction: a tuning multiply, two smoothing multiplies, then for each edge
//   correction that is needed a divide and a squaring multiply, then the output sample.
// One item in flight: the next is taken the cycle after the sample is registered.
// Reset (synchronous, active low): phase and step clear, registers take reset values.
`timescale 1ns / 1ps
module polyblep_oscillator import pbo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  `include "polyblep_oscillator_assert.svh"

  typedef enum logic [2:0] {
    S_IDLE, S_TUNE, S_SM1, S_SM2, S_BLEP, S_BDIV, S_BX, S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [31:0]        target_r, target_nxt;
  logic               wave_r, wave_nxt;
  logic signed [6:0]  cents_r, cents_nxt;
  logic [15:0]        coeff_r, coeff_nxt;
  logic [31:0]        phase_r, phase_nxt;
  logic [31:0]        step_r, step_nxt;
  logic [31:0]        tuned_r, tuned_nxt;
  logic [63:0]        accsm_r, accsm_nxt;
  logic               restart_r, restart_nxt;
  logic signed [34:0] v_r, v_nxt;
  logic               pass_r, pass_nxt;
  logic [31:0]        bx_r, bx_nxt;
  logic               bneg_r, bneg_nxt;
  logic               ov_r, ov_nxt;
  logic signed [15:0] sample_r, sample_nxt;

  logic               mstart, dstart, mdone, ddone;
  logic [31:0]        ma, mb, dnum, quo;
  logic [63:0]        prod;
  logic               in_fire, cfg_fire;
  logic signed [6:0]  cl_cents;
  logic [6:0]         gain_idx;
  logic [31:0]        gain_rom [0:100];
  logic [31:0]        tgt_sat, tuned_c, pass_t;
  logic [63:0]        tsum, ssum;
  logic [16:0]        coeff_c;
  logic [32:0]        tail, rest_t;
  logic               near_lo, near_hi;
  logic signed [34:0] naive, bx_s, sq_s, bval, vupd, vclip;
  logic [34:0]        qfull;
  logic signed [17:0] qv;
  logic signed [15:0] sat;

  pbo_serial_mul u_mul (.clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb),
                        .done(mdone), .prod(prod));
  pbo_serial_div u_div (.clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum), .den(step_r),
                        .done(ddone), .quo(quo));

  // Handshakes: take a transaction whenever the sequencer is idle
  assign in_ready   = (state_r == S_IDLE);
  assign cfg_ready  = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign out_valid  = ov_r;
  assign out_sample = sample_r;

  // Tuning gain table, one entry per cent from -50 to 50
  for (genvar gi = 0; gi <= 100; gi++) begin : g_gain
    assign gain_rom[gi] = tune_gain(7'(gi - 50));
  end

  assign cl_cents = (cents_r > 7'sd50) ? 7'sd50 : (cents_r < -7'sd50) ? -7'sd50 : cents_r;
  assign gain_idx = cl_cents + 7'sd50;
  assign tgt_sat  = (target_r > STEP_MAX) ? STEP_MAX : target_r;

  // Round the tuned step and form the smoothed step
  assign tsum    = prod + 64'd536870912;
  assign tuned_c = tsum[61:30];
  assign ssum    = accsm_r + prod + 64'd32768;
  assign coeff_c = 17'h1_0000 - {1'b0, coeff_r};

  // Pass 0 is the edge at phase, pass 1 the square's edge at half phase
  assign pass_t  = pass_r ? phase_r + 32'h8000_0000 : phase_r;
  assign tail    = 33'h1_0000_0000 - {1'b0, step_r};
  assign rest_t  = 33'h1_0000_0000 - {1'b0, pass_t};
  assign near_lo = pass_t < step_r;
  assign near_hi = {1'b0, pass_t} > tail;
  assign dnum    = near_lo ? pass_t : rest_t[31:0];

  // Naive wave: sawtooth from phase, square from its top bit
  assign naive = wave_r ? (phase_r[31] ? -35'sd1073741824 : 35'sd1073741824)
                        : $signed({4'b0, phase_r[31:1]}) - 35'sd1073741824;

  // BLEP from x: 2x - x^2 - 1 after the wrap, 1 - 2y + y^2 before it
  assign bx_s = $signed({3'b0, bx_r});
  assign sq_s = $signed({1'b0, prod[63:30]});
  assign bval = bneg_r ? (35'sd1073741824 - (bx_s <<< 1) + sq_s)
                       : ((bx_s <<< 1) - sq_s - 35'sd1073741824);
  assign vupd = (wave_r && !pass_r) ? v_r + bval : v_r - bval;

  // Clip to one, round half up to 16 bits and keep the range symmetric
  assign vclip = (v_r > 35'sd1073741824) ? 35'sd1073741824
               : (v_r < -35'sd1073741824) ? -35'sd1073741824 : v_r;
  assign qfull = vclip + 35'sd1073758208;
  assign qv    = $signed({1'b0, qfull[31:15]}) - 18'sd32768;
  assign sat   = (qv > 18'sd32767) ? 16'sh7FFF : (qv < -18'sd32767) ? 16'sh8001 : qv[15:0];

  // Start strobes and operands for the shared units
  always_comb begin
    mstart = 1'b0; ma = tgt_sat; mb = gain_rom[gain_idx];
    dstart = 1'b0;
    case (state_r)
      S_IDLE: begin
        mstart = in_fire;
      end
      S_TUNE: begin
        mstart = mdone; ma = restart_r ? tuned_c : step_r; mb = {16'b0, coeff_r};
      end
      S_SM1: begin
        mstart = mdone; ma = tuned_r; mb = {15'b0, coeff_c};
      end
      S_BLEP: begin
        dstart = near_lo || near_hi;
      end
      S_BDIV: begin
        mstart = ddone; ma = quo; mb = quo;
      end
      default: ;
    endcase
  end

  // Sequencer: register writes; tune, smooth, naive wave, corrections, advance, output
  always_comb begin
    state_nxt = state_r; target_nxt = target_r; wave_nxt = wave_r; cents_nxt = cents_r;
    coeff_nxt = coeff_r; phase_nxt = phase_r; step_nxt = step_r; tuned_nxt = tuned_r;
    accsm_nxt = accsm_r; restart_nxt = restart_r; v_nxt = v_r; pass_nxt = pass_r;
    bx_nxt = bx_r; bneg_nxt = bneg_r; sample_nxt = sample_r;
    ov_nxt = ov_r && !out_ready;
    if (cfg_fire) begin
      case (cfg_index)
        REG_TARGET: target_nxt = cfg_data;
        REG_WAVE:   wave_nxt   = cfg_data[0];
        REG_CENTS:  cents_nxt  = $signed(cfg_data[6:0]);
        REG_COEFF:  coeff_nxt  = cfg_data[15:0];
        default: ;
      endcase
    end
    case (state_r)
      S_IDLE: if (in_fire) begin
        restart_nxt = in_restart; state_nxt = S_TUNE;
      end
      S_TUNE: if (mdone) begin
        tuned_nxt = tuned_c;
        if (restart_r) phase_nxt = '0;
        state_nxt = S_SM1;
      end
      S_SM1: if (mdone) begin
        accsm_nxt = prod; state_nxt = S_SM2;
      end
      S_SM2: if (mdone) begin
        step_nxt = ssum[47:16]; v_nxt = naive; pass_nxt = 1'b0; state_nxt = S_BLEP;
      end
      S_BLEP: begin
        if (near_lo || near_hi) begin
          bneg_nxt = !near_lo; state_nxt = S_BDIV;
        end else if (wave_r && !pass_r) begin
          pass_nxt = 1'b1;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_BDIV: if (ddone) begin
        bx_nxt = quo; state_nxt = S_BX;
      end
      S_BX: if (mdone) begin
        v_nxt = vupd;
        if (wave_r && !pass_r) begin
          pass_nxt = 1'b1; state_nxt = S_BLEP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: if (!ov_r || out_ready) begin
        sample_nxt = sat; ov_nxt = 1'b1; phase_nxt = phase_r + step_r; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; target_r <= '0; wave_r <= 1'b0; cents_r <= '0;
      coeff_r <= 16'd65208; phase_r <= '0; step_r <= '0; tuned_r <= '0;
      accsm_r <= '0; restart_r <= 1'b0; v_r <= '0; pass_r <= 1'b0;
      bx_r <= '0; bneg_r <= 1'b0; ov_r <= 1'b0; sample_r <= '0;
    end else begin
      state_r <= state_nxt; target_r <= target_nxt; wave_r <= wave_nxt; cents_r <= cents_nxt;
      coeff_r <= coeff_nxt; phase_r <= phase_nxt; step_r <= step_nxt; tuned_r <= tuned_nxt;
      accsm_r <= accsm_nxt; restart_r <= restart_nxt; v_r <= v_nxt; pass_r <= pass_nxt;
      bx_r <= bx_nxt; bneg_r <= bneg_nxt; ov_r <= ov_nxt; sample_r <= sample_nxt;
    end
  end

  `PBO_ASSERT_NXT(a_out_hold, ov_r && !out_ready, ov_r && $stable(sample_r))
  `PBO_ASSERT_IMP(a_no_accept_busy, state_r != S_IDLE, !in_ready)
  `PBO_ASSERT_IMP(a_cents_clip, 1'b1, cl_cents <= 7'sd50 && cl_cents >= -7'sd50)
  `PBO_ASSERT_IMP(a_sample_sym, ov_r, sample_r != 16'sh8000)
endmodule

[tb/tb_top.sv]
// Self-checking testbench for the PolyBLEP oscillator: random traffic, scoreboard, watchdog
`timescale 1ns / 1ps
module tb_top import pbo_pkg::*; ();

  localparam int      LATENCY_WAIT = 400;
  localparam int      STALL_LIMIT  = 6000;
  localparam longint  Q30          = 64'sd1073741824;
  localparam longint  FULL_CYCLE   = 64'sd4294967296;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_restart = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_sample;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_TARGET;
  logic [31:0]        cfg_data = '0;

  polyblep_oscillator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_restart(in_restart),
    .out_valid(out_valid), .out_ready(out_ready), .out_sample(out_sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Oscillator shadow: registers and state
  logic [31:0]        osc_target;
  logic               osc_square;
  logic signed [6:0]  osc_cents;
  logic [15:0]        osc_coeff;
  logic [31:0]        osc_phase;
  logic [31:0]        osc_step;

  bit                 restart_queue[$];
  logic signed [15:0] expected_samples[$];
  int                 sent_count = 0;
  int                 taken_count = 0;
  int                 error_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 hold_left = 0;
  bit                 hold_request = 1'b0;
  int                 quiet_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Gain 2^(c/1200) in Q2.30 by cubic series, cents already limited
  function automatic longint cents_gain(input longint c);
    longint u, u2, u3;
    u  = c * 64'sd620218;
    u2 = (u * u) / (2 * Q30);
    u3 = (u2 * u) / (3 * Q30);
    return Q30 + u + u2 + u3;
  endfunction

  // Band-limiting step correction around a discontinuity at t = 0
  function automatic longint edge_correction(input longint t, input longint dt);
    longint x;
    if (dt == 0) return 0;
    if (t < dt) begin
      x = (t <<< 30) / dt;
      return 2 * x - (x * x) / Q30 - Q30;
    end
    if (t > FULL_CYCLE - dt) begin
      x = ((FULL_CYCLE - t) <<< 30) / dt;
      return Q30 - 2 * x + (x * x) / Q30;
    end
    return 0;
  endfunction

  // Produce the next sample and advance the shadow state
  function automatic logic signed [15:0] next_sample(input bit restart);
    longint c, t, dt, v, q;
    longint unsigned step_in, tuned, smooth;
    step_in = (osc_target > STEP_MAX) ? STEP_MAX : osc_target;
    c = osc_cents;
    if (c > CENT_LIM) c = CENT_LIM;
    if (c < -CENT_LIM) c = -CENT_LIM;
    tuned = (step_in * longint'(cents_gain(c)) + (64'd1 << 29)) >> 30;
    if (restart) begin
      osc_phase = '0;
      osc_step  = tuned[31:0];
    end
    smooth = (longint'(osc_step) * osc_coeff + tuned * (65536 - osc_coeff) + 32768) >> 16;
    osc_step = smooth[31:0];
    t  = osc_phase;
    dt = osc_step;
    if (!osc_square) begin
      v = (t >>> 1) - Q30 - edge_correction(t, dt);
    end else begin
      v = (t < 64'sd2147483648) ? Q30 : -Q30;
      v = v + edge_correction(t, dt)
            - edge_correction((t + 64'sd2147483648) % FULL_CYCLE, dt);
    end
    osc_phase = osc_phase + osc_step;
    if (v > Q30) v = Q30;
    if (v < -Q30) v = -Q30;
    q = ((v + Q30) + (64'sd1 << 14)) >>> 15;
    v = q - 32768;
    if (v > 32767) v = 32767;
    if (v < -32767) v = -32767;
    return v[15:0];
  endfunction

  // Input and output monitor: predict on accept, compare on result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_samples.push_back(next_sample(in_restart));
        taken_count <= taken_count + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected sample %0d", out_sample);
        end else begin
          if (out_sample !== expected_samples[0]) begin
            error_count++;
            if (error_count <= 10)
              $display("sample mismatch: expected %0d got %0d",
                       expected_samples[0], out_sample);
          end
          void'(expected_samples.pop_front());
        end
      end
    end
  end

  // Driver: offer the next pending transaction once the previous one is taken
  always @(negedge clk) begin
    if (rst_n && (!in_valid || taken_count == sent_count)) begin
      if (restart_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_restart <= restart_queue.pop_front();
        in_valid   <= 1'b1;
        sent_count <= sent_count + 1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_request = 1'b0;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TARGET: osc_target = data;
      REG_WAVE:   osc_square = data[0];
      REG_CENTS:  osc_cents  = data[6:0];
      default:    osc_coeff  = data[15:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_voice(input logic [31:0] target, input bit square,
                           input logic [6:0] cents, input logic [15:0] coeff);
    write_reg(REG_TARGET, target);
    write_reg(REG_WAVE, {31'd0, square});
    write_reg(REG_CENTS, {25'd0, cents});
    write_reg(REG_COEFF, {16'd0, coeff});
  endtask

  // Wait until every transaction has produced its sample, then let the block settle
  task automatic drain();
    while (restart_queue.size() != 0 || in_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (LATENCY_WAIT) @(posedge clk);
  endtask

  task automatic queue_items(input int count, input int restart_pct);
    repeat (count) restart_queue.push_back($urandom_range(99) < restart_pct);
  endtask

  initial begin
    logic [31:0] target;
    int          pick;
    osc_target = '0;
    osc_square = 1'b0;
    osc_cents  = '0;
    osc_coeff  = 16'd65208;
    osc_phase  = '0;
    osc_step   = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset defaults with zero step, then extremes of every register
    queue_items(2, 0);
    drain();
    set_voice(32'hFFFF_FFFF, 1'b0, 7'h3F, 16'd0);
    restart_queue.push_back(1'b1);
    queue_items(3, 0);
    drain();
    set_voice(32'd2104533975, 1'b1, 7'h40, 16'd65535);
    restart_queue.push_back(1'b1);
    queue_items(3, 0);
    drain();
    set_voice(32'h1000_0000, 1'b1, 7'd50, 16'd32768);
    restart_queue.push_back(1'b1);
    queue_items(6, 0);
    restart_queue.push_back(1'b1);
    drain();
    set_voice(32'h0800_0001, 1'b0, 7'h4E, 16'd65208);
    queue_items(6, 30);
    drain();

    // Random phases with fresh settings, idling pattern changing by thirds
    for (int ph = 0; ph < 8; ph++) begin
      send_idle_pct = (ph < 3) ? 6 : (ph < 6) ? 48 : 0;
      recv_idle_pct = (ph < 3) ? 48 : (ph < 6) ? 6 : 0;
      pick = $urandom_range(3);
      target = (pick == 0) ? $urandom : (pick == 1) ? $urandom_range(32'h0400_0000)
             : (pick == 2) ? $urandom_range(32'h7FFF_FFFF, 32'h6000_0000) : $urandom;
      set_voice(target, 1'($urandom_range(1)), 7'($urandom_range(127)),
                16'(($urandom_range(3) == 0) ? $urandom_range(65535)
                                             : $urandom_range(65535, 60000)));
      queue_items(100, 8);
      if (ph == 1) hold_request = 1'b1;
      drain();
    end

    if (error_count == 0 && expected_samples.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
